// File: rtl/cirs_pkg.sv
package cirs_pkg;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_ABORT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        K_READY      = 3'd0,
        K_ACK        = 3'd1,
        K_DONE       = 3'd2,
        K_BUSY       = 3'd3,
        K_BAD_START  = 3'd4,
        K_SEQ_ERR    = 3'd5,
        K_DECODE_ERR = 3'd6,
        K_DATA       = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FETCH,
        B_DATA,
        B_ACK,
        B_DONE
    } back_state_t;

    // Register index decoded from paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    localparam int CC_W = 7;
    localparam logic [CC_W-1:0] CC_MAX = 7'd127;
    // Byte count of one chunk; holds up to the largest chunk size
    localparam int LEN_W = 6;

    localparam logic [7:0] CH_DIGIT_LO = 8'h30;  // '0'
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;  // '9'
    localparam logic [7:0] CH_LOWER_LO = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOWER_HI = 8'h66;  // 'f'
    localparam logic [7:0] CH_UPPER_LO = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPPER_HI = 8'h46;  // 'F'
    localparam logic [7:0] HEX_TEN     = 8'd10;

    // One queued reply: a single result, or a chunk burst (data bytes, ack, maybe done)
    typedef struct packed {
        kind_t             kind;
        logic [15:0]       value;
        logic [23:0]       size;
        logic [31:0]       crc;
        logic              burst;
        logic              done;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // Returns {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'd0;
        d = 8'd0;
        if (c >= CH_DIGIT_LO && c <= CH_DIGIT_HI) begin
            d = c - CH_DIGIT_LO;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_LOWER_LO && c <= CH_LOWER_HI) begin
            d = c - CH_LOWER_LO + HEX_TEN;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_UPPER_LO && c <= CH_UPPER_HI) begin
            d = c - CH_UPPER_LO + HEX_TEN;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/cirs_if.sv
interface cirs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] chunk_count;
    logic [23:0] image_size;
    logic [31:0] image_crc;
    logic [15:0] chunk_index;
    logic [7:0]  hex_char;
    logic        last_char;
    logic        dispense_busy;

    modport source (
        output valid, action, chunk_count, image_size, image_crc,
               chunk_index, hex_char, last_char, dispense_busy,
        input  ready
    );
    modport sink (
        input  valid, action, chunk_count, image_size, image_crc,
               chunk_index, hex_char, last_char, dispense_busy,
        output ready
    );
endinterface

interface cirs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] value;
    logic [23:0] size_out;
    logic [31:0] crc_out;
    logic        last;

    modport source (
        output valid, kind, value, size_out, crc_out, last,
        input  ready
    );
    modport sink (
        input  valid, kind, value, size_out, crc_out, last,
        output ready
    );
endinterface

// File: rtl/cirs_ram.sv
module cirs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/cirs_queue.sv
module cirs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cirs_pkg::cmd_t push_cmd,
    input  logic           pop,
    output cirs_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import cirs_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
endmodule

// File: rtl/cirs_front.sv
module cirs_front #(
    parameter int CHUNK_BYTES = 32,
    parameter int IDX_W       = 5,
    parameter int ADDR_W      = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    cirs_in_if.sink           in_ch,
    input  logic [31:0]       timeout_ticks,
    input  logic              q_full,
    output logic              q_push,
    output cirs_pkg::cmd_t    q_cmd,
    input  logic              burst_done,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data
);
    import cirs_pkg::*;

    localparam logic [CC_W-1:0] CC_LIMIT = CC_W'(2 * CHUNK_BYTES);

    logic             active_reg, active_next;
    logic [15:0]      total_reg, total_next;
    logic [15:0]      expected_reg, expected_next;
    logic [23:0]      size_reg, size_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      idle_reg, idle_next;
    logic [CC_W-1:0]  cc_reg, cc_next;
    logic [3:0]       hn_reg, hn_next;
    logic             bad_reg, bad_next;
    logic             wr_bank_reg, wr_bank_next;
    logic [1:0]       bursts_reg, bursts_next;

    logic             accept;
    logic             drop;
    logic             push_burst;
    logic [IDX_W-1:0] wr_idx;

    assign in_ch.ready = !q_full && (bursts_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [4:0]      nib;
        logic [3:0]      nib_val;
        logic [CC_W-1:0] cc_new;
        logic            bad_new;
        logic [15:0]     exp_inc;
        logic [31:0]     idle_inc;

        active_next   = active_reg;
        total_next    = total_reg;
        expected_next = expected_reg;
        size_next     = size_reg;
        crc_next      = crc_reg;
        idle_next     = idle_reg;
        cc_next       = cc_reg;
        hn_next       = hn_reg;
        bad_next      = bad_reg;
        drop          = 1'b0;
        push_burst    = 1'b0;
        q_push        = 1'b0;
        q_cmd         = '0;
        wr_en         = 1'b0;
        wr_idx        = cc_reg[IDX_W:1];

        nib      = hex_nibble(in_ch.hex_char);
        nib_val  = nib[4] ? nib[3:0] : 4'd0;
        wr_data  = {hn_reg, nib_val};
        cc_new   = cc_reg;
        bad_new  = bad_reg;
        exp_inc  = expected_reg + 16'd1;
        idle_inc = (idle_reg != '1) ? idle_reg + 32'd1 : idle_reg;

        if (accept)
        begin
            unique case (action_t'(in_ch.action))
                ACT_START:
                begin
                    q_push = 1'b1;
                    if (in_ch.dispense_busy)
                    begin
                        q_cmd.kind = K_BUSY;
                    end
                    else if (in_ch.chunk_count == 16'd0 || in_ch.image_size == 24'd0)
                    begin
                        q_cmd.kind = K_BAD_START;
                    end
                    else
                    begin
                        q_cmd.kind    = K_READY;
                        q_cmd.value   = 16'(CHUNK_BYTES);
                        active_next   = 1'b1;
                        total_next    = in_ch.chunk_count;
                        expected_next = 16'd0;
                        size_next     = in_ch.image_size;
                        crc_next      = in_ch.image_crc;
                        idle_next     = 32'd0;
                        cc_next       = '0;
                        hn_next       = 4'd0;
                        bad_next      = 1'b0;
                    end
                end
                ACT_CHAR:
                begin
                    bad_new = bad_reg | !nib[4];
                    if (cc_reg >= CC_LIMIT)
                    begin
                        bad_new = 1'b1;
                    end
                    else if (!cc_reg[0])
                    begin
                        hn_next = nib_val;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                    cc_new   = (cc_reg != CC_MAX) ? cc_reg + 1'b1 : cc_reg;
                    cc_next  = cc_new;
                    bad_next = bad_new;

                    if (in_ch.last_char)
                    begin
                        // Chunk text always clears at chunk end
                        cc_next  = '0;
                        hn_next  = 4'd0;
                        bad_next = 1'b0;
                        if (active_reg)
                        begin
                            if (idle_reg > timeout_ticks)
                            begin
                                drop = 1'b1;
                            end
                            else if (in_ch.dispense_busy)
                            begin
                                drop       = 1'b1;
                                q_push     = 1'b1;
                                q_cmd.kind = K_BUSY;
                            end
                            else if (in_ch.chunk_index < expected_reg)
                            begin
                                q_push     = 1'b1;
                                q_cmd.kind = K_SEQ_ERR;
                            end
                            else if (in_ch.chunk_index != expected_reg)
                            begin
                                drop       = 1'b1;
                                q_push     = 1'b1;
                                q_cmd.kind = K_SEQ_ERR;
                            end
                            else if (bad_new || cc_new[0] || cc_new == '0 || cc_new > CC_LIMIT)
                            begin
                                drop       = 1'b1;
                                q_push     = 1'b1;
                                q_cmd.kind = K_DECODE_ERR;
                            end
                            else
                            begin
                                q_push        = 1'b1;
                                push_burst    = 1'b1;
                                q_cmd.kind    = K_ACK;
                                q_cmd.burst   = 1'b1;
                                q_cmd.value   = in_ch.chunk_index;
                                q_cmd.len     = cc_new[LEN_W:1];
                                q_cmd.size    = size_reg;
                                q_cmd.crc     = crc_reg;
                                expected_next = exp_inc;
                                idle_next     = 32'd0;
                                if (exp_inc >= total_reg)
                                begin
                                    q_cmd.done = 1'b1;
                                    drop       = 1'b1;
                                end
                            end
                        end
                    end
                end
                ACT_TICK:
                begin
                    if (active_reg)
                    begin
                        idle_next = idle_inc;
                        if (idle_inc > timeout_ticks)
                        begin
                            drop = 1'b1;
                        end
                    end
                end
                ACT_ABORT:
                begin
                    drop     = 1'b1;
                    cc_next  = '0;
                    hn_next  = 4'd0;
                    bad_next = 1'b0;
                end
                default:
                begin
                    drop = 1'b0;
                end
            endcase
        end

        if (drop)
        begin
            active_next   = 1'b0;
            total_next    = 16'd0;
            expected_next = 16'd0;
            size_next     = 24'd0;
            crc_next      = 32'd0;
            idle_next     = 32'd0;
        end
    end

    // Each burst owns one buffer bank until the back end has read it out
    assign wr_bank_next = push_burst ? ~wr_bank_reg : wr_bank_reg;
    assign bursts_next  = bursts_reg + {1'b0, push_burst} - {1'b0, burst_done};
    assign wr_addr      = ADDR_W'(wr_idx) + (wr_bank_reg ? ADDR_W'(CHUNK_BYTES) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            total_reg    <= 16'd0;
            expected_reg <= 16'd0;
            size_reg     <= 24'd0;
            crc_reg      <= 32'd0;
            idle_reg     <= 32'd0;
            cc_reg       <= '0;
            hn_reg       <= 4'd0;
            bad_reg      <= 1'b0;
            wr_bank_reg  <= 1'b0;
            bursts_reg   <= 2'd0;
        end
        else
        begin
            active_reg   <= active_next;
            total_reg    <= total_next;
            expected_reg <= expected_next;
            size_reg     <= size_next;
            crc_reg      <= crc_next;
            idle_reg     <= idle_next;
            cc_reg       <= cc_next;
            hn_reg       <= hn_next;
            bad_reg      <= bad_next;
            wr_bank_reg  <= wr_bank_next;
            bursts_reg   <= bursts_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_release_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
        burst_done |-> (bursts_reg != 2'd0))
        else $error("burst released with no burst outstanding");
`endif
endmodule

// File: rtl/cirs_back.sv
module cirs_back #(
    parameter int CHUNK_BYTES = 32,
    parameter int IDX_W       = 5,
    parameter int ADDR_W      = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cirs_pkg::cmd_t    q_head,
    output logic              q_pop,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              burst_done,
    cirs_out_if.source        out_ch
);
    import cirs_pkg::*;

    back_state_t      state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [IDX_W-1:0] byte_reg, byte_next;
    logic             rd_bank_reg, rd_bank_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    logic [15:0]      out_value_reg, out_value_next;
    logic [23:0]      out_size_reg, out_size_next;
    logic [31:0]      out_crc_reg, out_crc_next;
    logic             out_last_reg, out_last_next;

    logic             slot_free;
    logic             load;

    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        byte_next      = byte_reg;
        rd_bank_next   = rd_bank_reg;
        q_pop          = 1'b0;
        burst_done     = 1'b0;
        load           = 1'b0;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_size_next  = out_size_reg;
        out_crc_next   = out_crc_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    if (q_head.burst)
                    begin
                        byte_next  = '0;
                        state_next = B_FETCH;
                    end
                    else
                    begin
                        load           = 1'b1;
                        out_kind_next  = q_head.kind;
                        out_value_next = q_head.value;
                        out_size_next  = q_head.size;
                        out_crc_next   = q_head.crc;
                        out_last_next  = 1'b1;
                    end
                end
            end
            B_FETCH:
            begin
                state_next = B_DATA;
            end
            B_DATA:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    out_kind_next  = K_DATA;
                    out_value_next = {8'd0, rd_data};
                    out_size_next  = 24'd0;
                    out_crc_next   = 32'd0;
                    out_last_next  = 1'b0;
                    if (LEN_W'(byte_reg) + 1'b1 == cur_reg.len)
                    begin
                        state_next = B_ACK;
                    end
                    else
                    begin
                        byte_next  = byte_reg + 1'b1;
                        state_next = B_FETCH;
                    end
                end
            end
            B_ACK:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    out_kind_next  = K_ACK;
                    out_value_next = cur_reg.value;
                    out_size_next  = 24'd0;
                    out_crc_next   = 32'd0;
                    out_last_next  = !cur_reg.done;
                    burst_done     = 1'b1;
                    rd_bank_next   = ~rd_bank_reg;
                    state_next     = cur_reg.done ? B_DONE : B_IDLE;
                end
            end
            B_DONE:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    out_kind_next  = K_DONE;
                    out_value_next = 16'd0;
                    out_size_next  = cur_reg.size;
                    out_crc_next   = cur_reg.crc;
                    out_last_next  = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rd_addr = ADDR_W'(byte_reg) + (rd_bank_reg ? ADDR_W'(CHUNK_BYTES) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            byte_reg      <= '0;
            rd_bank_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            rd_bank_reg   <= rd_bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_size_reg  <= out_size_next;
        out_crc_reg   <= out_crc_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.kind     = out_kind_reg;
    assign out_ch.value    = out_value_reg;
    assign out_ch.size_out = out_size_reg;
    assign out_ch.crc_out  = out_crc_reg;
    assign out_ch.last     = out_last_reg;

`ifndef SYNTHESIS
    a_byte_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DATA) |-> (LEN_W'(byte_reg) < cur_reg.len))
        else $error("data byte index past chunk length");

    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == K_DATA) |-> !out_last_reg)
        else $error("data byte flagged as final result");
`endif
endmodule

// File: rtl/chunked_image_receive_session_top.sv
// Chunked image receive session. Input beats carry one action each: start (arms a session
// and answers ready with the chunk size, or busy / bad start), chunk character (hex text,
// decoded two characters per byte into a two-bank chunk buffer), tick (ages the session
// against timeout_ticks) and abort. The front end takes one input beat per clock while
// ready is high and classifies it in that cycle; on a chunk's last character it checks
// session, timeout, busy, index and decode, and queues one reply command into a two-entry
// queue unless no session is active or it has timed out. The back end drains that queue
// through a registered output: a single reply is loaded as it is dequeued; a good chunk
// is dequeued, then each data byte is read from the buffer and then loaded into the
// output, then the ack is loaded and, after the final chunk, a done. Each load waits for
// the sink to free the output register. The input stalls only when the queue is full or
// both buffer banks still hold chunks waiting to be read out. The buffer needs no clearing
// after reset; only bytes written for the current chunk are read. timeout_ticks sits at
// byte address 0 of the APB port; change it only while the block is idle.
module chunked_image_receive_session_top #(
    parameter int CHUNK_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    cirs_in_if.sink     in_ch,
    cirs_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cirs_pkg::*;

    // Byte slot within a bank, and address over both banks
    localparam int IDX_W  = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int ADDR_W = $clog2(2 * CHUNK_BYTES);

    logic [31:0]       timeout_reg, timeout_next;
    logic              cfg_write;

    logic              q_push, q_pop, q_full, q_empty;
    cmd_t              q_cmd, q_head;
    logic              burst_done;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;

    // Config port: zero-wait writes at the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_write && paddr[2] == REG_TIMEOUT)
        begin
            timeout_next = pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // Front end: session state, hex decode, chunk checks
    cirs_front #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .IDX_W       (IDX_W),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .timeout_ticks (timeout_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd),
        .burst_done    (burst_done),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // Reply commands between the two halves
    cirs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Two banks of decoded chunk bytes
    cirs_ram #(
        .WIDTH (8),
        .DEPTH (2 * CHUNK_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Back end: expand commands into result beats
    cirs_back #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .IDX_W       (IDX_W),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .burst_done (burst_done),
        .out_ch     (out_ch)
    );
endmodule
